// File: sv/can_command_frame_processor_top_macros.svh
// Assertion macros shared by the frame processor modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CAN_COMMAND_FRAME_PROCESSOR_TOP_MACROS_SVH
`define CAN_COMMAND_FRAME_PROCESSOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/can_cfp_pkg.sv
// Shared constants, result kind codes and helper functions for the CAN
// command frame processor. No dependencies.
package can_cfp_pkg;

    localparam int PARAM_COUNT_DEF = 32;
    localparam int ID_W            = 11;
    localparam int DATA_W          = 56;
    localparam int VALUE_W         = 32;
    localparam int REPLY_W         = 40;
    localparam int TORQUE_W        = 16;
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 72;
    localparam int CRC_BYTES       = 6;

    localparam logic [2:0] KIND_REPLY  = 3'd0;
    localparam logic [2:0] KIND_STORED = 3'd1;
    localparam logic [2:0] KIND_TORQUE = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_RAMP   = 3'd4;

    localparam logic       CFG_RX_BASE = 1'b0;
    localparam logic       CFG_TX_BASE = 1'b1;

    localparam logic [7:0]  CRC_POLY     = 8'hAD;
    localparam logic [7:0]  PARAM_MASK   = 8'h7F;
    localparam logic [7:0]  RAMP_MAGIC0  = 8'h10;
    localparam logic [7:0]  RAMP_MAGIC1  = 8'hDE;
    localparam logic [7:0]  GEAR_DRIVE   = 8'd3;
    localparam logic [7:0]  GEAR_REVERSE = 8'd5;
    localparam logic [10:0] REPLY_ID_OFS = 11'h010;

    localparam logic [11:0] OFS_PARAM = 12'd0;
    localparam logic [11:0] OFS_RAMP  = 12'd1;
    localparam logic [11:0] OFS_POWER = 12'd2;

    function automatic logic [2:0] param_bytes(input logic [6:0] p);
        logic [2:0] n;
        case (p) inside
            7'd14, 7'd15, 7'd17, 7'd18, 7'd29, 7'd30, 7'd31:
                n = 3'd1;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd16, [7'd23:7'd28]:
                n = 3'd2;
            default:
                n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] width_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        case (nbytes)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: sv/can_cfp_crc.sv
// Byte-serial CRC-8 unit: shifts the six covered bytes through one per cycle.
// Depends on can_cfp_pkg.
module can_cfp_crc
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] din,
    output logic        done,
    output logic [7:0]  crc
);

    logic [47:0] shift_reg, shift_next;
    logic [7:0]  crc_reg, crc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        shift_next = shift_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = din;
            crc_next   = 8'd0;
            cnt_next   = 3'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next   = can_cfp_pkg::crc8_byte(crc_reg, shift_reg[7:0]);
            shift_next = shift_reg >> 8;
            cnt_next   = cnt_reg + 3'd1;
            if (cnt_reg == 3'(can_cfp_pkg::CRC_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        crc_reg   <= crc_next;
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

// File: sv/can_cfp_store.sv
// Parameter store: one write port, one registered read port, with per-entry
// valid bits so that entries never written read as zero. Depends on can_cfp_pkg.
module can_cfp_store
#(
    parameter int DEPTH = can_cfp_pkg::PARAM_COUNT_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic                           re,
    input  logic [IDX_W-1:0]               addr,
    input  logic [can_cfp_pkg::VALUE_W-1:0] wdata,
    output logic [can_cfp_pkg::VALUE_W-1:0] rdata
);

    logic [can_cfp_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]                valid_reg;
    logic [can_cfp_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/can_command_frame_processor_top.sv
// Top level of the CAN command frame processor: frame decoder, sequencer and
// output register. Depends on can_cfp_pkg, can_cfp_crc, can_cfp_store and the macros header.
//
// Channel   Dir  Handshake        Payload
// s_*       in   tvalid/tready    tdata: frame_id[10:0], frame_data[66:11]
// m_*       out  tvalid/tready    tuser: kind; tdata: reply fields, torque, ramp_on
// cfg_*     in   cfg_we           cfg_index selects rx_base_id or tx_base_id
//
// One frame is handled at a time; s_tready is high only while the sequencer idles.
// Ramp frames and parameter writes pass from decode to emit, parameter reads also go
// through the store read state, and power frames wait in the CRC state while the
// byte-serial CRC unit works; a power frame that gives no result skips emit.
// Reset clears the parameter valid bits, base ids and all handshake state at once.
// A full output register holds the sequencer until the result is taken.
`include "can_command_frame_processor_top_macros.svh"

module can_command_frame_processor_top
#(
    parameter int PARAM_COUNT = can_cfp_pkg::PARAM_COUNT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // frame_id [10:0], frame_data [66:11], zero fill [71:67]
    input  logic [can_cfp_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // reply_id [10:0], reply_length [13:11], reply_data [53:14], torque [69:54],
    // ramp_on [70], zero fill [71]
    output logic [can_cfp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // kind [2:0]
    output logic [2:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [can_cfp_pkg::ID_W-1:0]        cfg_data
);

    localparam int IDX_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CRC    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [10:0] rx_base_reg, tx_base_reg;
    logic [10:0] id_reg, id_next;
    logic [55:0] data_reg, data_next;

    logic [2:0]         res_kind_reg, res_kind_next;
    logic [10:0]        res_id_reg, res_id_next;
    logic [2:0]         res_len_reg, res_len_next;
    logic [39:0]        res_data_reg, res_data_next;
    logic signed [15:0] res_torque_reg, res_torque_next;
    logic               res_ramp_reg, res_ramp_next;

    logic        out_valid_reg, out_valid_next;
    logic [71:0] out_tdata_reg, out_tdata_next;
    logic [2:0]  out_tuser_reg, out_tuser_next;

    logic [11:0] offset;
    logic [6:0]  pnum;
    logic        p_ok;
    logic [2:0]  pbytes;
    logic [31:0] pmask;
    logic [15:0] speed;

    logic        crc_start, crc_done;
    logic [7:0]  crc_value;
    logic        st_we, st_re;
    logic [31:0] st_rdata;

    assign offset = {1'b0, id_reg} - {1'b0, rx_base_reg};
    assign pnum   = data_reg[6:0] & can_cfp_pkg::PARAM_MASK[6:0];
    assign p_ok   = {1'b0, pnum} < 8'(PARAM_COUNT);
    assign pbytes = can_cfp_pkg::param_bytes(pnum);
    assign pmask  = can_cfp_pkg::width_mask(pbytes);
    assign speed  = data_reg[15] ? 16'd0 : data_reg[15:0];

    can_cfp_crc u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crc_start),
        .din   (data_reg[47:0]),
        .done  (crc_done),
        .crc   (crc_value)
    );

    can_cfp_store
    #(
        .DEPTH (PARAM_COUNT),
        .IDX_W (IDX_W)
    )
    u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .re    (st_re),
        .addr  (pnum[IDX_W-1:0]),
        .wdata (data_reg[39:8] & pmask),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        id_next         = id_reg;
        data_next       = data_reg;
        res_kind_next   = res_kind_reg;
        res_id_next     = res_id_reg;
        res_len_next    = res_len_reg;
        res_data_next   = res_data_reg;
        res_torque_next = res_torque_reg;
        res_ramp_next   = res_ramp_reg;
        out_valid_next  = out_valid_reg;
        out_tdata_next  = out_tdata_reg;
        out_tuser_next  = out_tuser_reg;
        crc_start       = 1'b0;
        st_we           = 1'b0;
        st_re           = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next    = s_tdata[10:0];
                    data_next  = s_tdata[66:11];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_id_next     = 11'd0;
                res_len_next    = 3'd0;
                res_data_next   = 40'd0;
                res_torque_next = 16'sd0;
                res_ramp_next   = 1'b0;
                state_next      = S_IDLE;
                if (!offset[11])
                begin
                    if (offset == can_cfp_pkg::OFS_PARAM)
                    begin
                        if (p_ok)
                        begin
                            if (data_reg[7])
                            begin
                                st_we         = 1'b1;
                                res_kind_next = can_cfp_pkg::KIND_STORED;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                state_next = S_READ;
                            end
                        end
                    end
                    else if (offset == can_cfp_pkg::OFS_RAMP)
                    begin
                        res_kind_next = can_cfp_pkg::KIND_RAMP;
                        res_ramp_next = (data_reg[7:0] == can_cfp_pkg::RAMP_MAGIC0) &&
                                        (data_reg[15:8] == can_cfp_pkg::RAMP_MAGIC1);
                        state_next    = S_EMIT;
                    end
                    else if (offset == can_cfp_pkg::OFS_POWER)
                    begin
                        crc_start  = 1'b1;
                        state_next = S_CRC;
                    end
                end
            end
            S_READ:
            begin
                res_kind_next = can_cfp_pkg::KIND_REPLY;
                res_id_next   = tx_base_reg + can_cfp_pkg::REPLY_ID_OFS;
                res_len_next  = pbytes + 3'd1;
                res_data_next = {st_rdata & pmask, 1'b0, pnum};
                state_next    = S_EMIT;
            end
            S_CRC:
            begin
                if (crc_done)
                begin
                    state_next = S_IDLE;
                    if (crc_value == data_reg[55:48])
                    begin
                        if (data_reg[39:32] == can_cfp_pkg::GEAR_DRIVE)
                        begin
                            res_kind_next   = can_cfp_pkg::KIND_TORQUE;
                            res_torque_next = (data_reg[31:16] == 16'd0) ?
                                              speed : data_reg[31:16];
                            state_next      = S_EMIT;
                        end
                        else if (data_reg[39:32] != can_cfp_pkg::GEAR_REVERSE)
                        begin
                            res_kind_next = can_cfp_pkg::KIND_STOP;
                            state_next    = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_tuser_next = res_kind_reg;
                    out_tdata_next = {1'b0, res_ramp_reg, res_torque_reg, res_data_reg,
                                      res_len_reg, res_id_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rx_base_reg   <= 11'd0;
            tx_base_reg   <= 11'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == can_cfp_pkg::CFG_RX_BASE)
            begin
                rx_base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == can_cfp_pkg::CFG_TX_BASE)
            begin
                tx_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        data_reg       <= data_next;
        res_kind_reg   <= res_kind_next;
        res_id_reg     <= res_id_next;
        res_len_reg    <= res_len_next;
        res_data_reg   <= res_data_next;
        res_torque_reg <= res_torque_next;
        res_ramp_reg   <= res_ramp_next;
        out_tdata_reg  <= out_tdata_next;
        out_tuser_reg  <= out_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    `CFP_ASSERT_NEXT(a_emit_holds, (state_reg == S_EMIT) && m_tvalid && !m_tready,
        state_reg == S_EMIT, "Result was dropped while the output register was full.")
    `CFP_ASSERT_NOW(a_crc_done_in_crc, crc_done, state_reg == S_CRC,
        "CRC unit finished outside the CRC wait state.")
    `CFP_ASSERT_NOW(a_reply_length, m_tvalid && (m_tuser == can_cfp_pkg::KIND_REPLY),
        (m_tdata[13:11] == 3'd2) || (m_tdata[13:11] == 3'd3) || (m_tdata[13:11] == 3'd5),
        "Parameter reply carries an illegal length.")
    `CFP_ASSERT_NOW(a_other_no_length, m_tvalid && (m_tuser != can_cfp_pkg::KIND_REPLY),
        (m_tdata[13:11] == 3'd0) && (m_tdata[10:0] == 11'd0),
        "Non-reply result carries reply id or length.")

endmodule
